// ===== rtl/sopb_pkg.sv =====
`default_nettype none

package sopb_pkg;

    // pipeline depth: input, products, rounding, second products, output
    localparam int NUM_STAGES = 5;

    // blend mode codes
    localparam logic [2:0] MODE_ARGB_ON_ARGB   = 3'd0;
    localparam logic [2:0] MODE_RGB_ON_RGB     = 3'd1;
    localparam logic [2:0] MODE_ARGB_ON_RGB565 = 3'd2;
    localparam logic [2:0] MODE_RGB_ON_RGB565  = 3'd3;
    localparam logic [2:0] MODE_RGB565_ON_565  = 3'd4;

    // configuration register indexes
    localparam logic REG_BLEND_MODE  = 1'b0;
    localparam logic REG_LAYER_ALPHA = 1'b1;

    // per-stage pipeline control
    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
        logic [NUM_STAGES-1:0] valid;
    } pipe_ctrl_t;

    // byte rounding of a channel product: (t + (t >> 8) + 128) >> 8
    function automatic logic [7:0] round_byte(input logic [16:0] t);
        logic [16:0] u;
        u = t + {8'd0, t[16:8]} + 17'd128;
        return u[15:8];
    endfunction

    // truncating 888 to 565 conversion
    function automatic logic [15:0] to_565(input logic [31:0] c);
        return {c[23:19], c[15:10], c[7:3]};
    endfunction

    // assemble a 565 multiply from its three field products
    function automatic logic [15:0] pick_565(input logic [10:0] pr,
                                             input logic [14:0] pg,
                                             input logic [10:0] pb);
        return {pr[10:6], pg[13:8], pb[10:6]};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/source_over_pixel_blender_unit.sv =====
`default_nettype none

// channel     | ports                                   | direction
// ------------+-----------------------------------------+----------
// pixel in    | s_valid s_ready s_src_pixel s_dst_pixel | in
// result out  | m_valid m_ready m_result_pixel          | out
// config      | cfg_we cfg_idx cfg_wdata                | in
//
// five register stages: input, channel products, rounding, products with the
// scaled source alpha, final add; one item per cycle while m_ready does not stall.
// the rate is set by the per-stage valid/load chain; the multipliers sit in
// stages two and four, the rounding adders in stages three and five.
// aresetn is synchronous: clears valid bits and sets mode 0, layer alpha 256.
// a stall at m_ready holds the output stage; upstream stages keep filling
// until they are full, so no item is lost or repeated.

module source_over_pixel_blender_unit (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [31:0] s_src_pixel,
    input  wire  [31:0] s_dst_pixel,
    output logic        m_valid,
    input  wire         m_ready,
    output logic [31:0] m_result_pixel,
    input  wire         cfg_we,
    input  wire         cfg_idx,
    input  wire  [8:0]  cfg_wdata
);
    import sopb_pkg::*;

    // configuration registers
    logic [2:0]  mode_reg,   mode_next;
    logic        opaque_reg, opaque_next;
    logic        clear_reg,  clear_next;
    logic [7:0]  alpha_reg,  alpha_next;
    logic [15:0] alpha_scaled;

    pipe_ctrl_t ctrl;

    // layer alpha to byte alpha: (ca * 255) >> 8
    always_comb begin
        alpha_scaled = {cfg_wdata[7:0], 8'd0} - {8'd0, cfg_wdata[7:0]};
        mode_next    = mode_reg;
        opaque_next  = opaque_reg;
        clear_next   = clear_reg;
        alpha_next   = alpha_reg;
        if (cfg_we) begin
            unique case (cfg_idx)
                REG_BLEND_MODE: begin
                    mode_next = cfg_wdata[2:0];
                end
                REG_LAYER_ALPHA: begin
                    opaque_next = cfg_wdata[8];
                    clear_next  = (cfg_wdata == 9'd0);
                    alpha_next  = cfg_wdata[8] ? 8'hff : alpha_scaled[15:8];
                end
                default: begin
                    mode_next = mode_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_ARGB_ON_ARGB;
            opaque_reg <= 1'b1;
            clear_reg  <= 1'b0;
            alpha_reg  <= 8'hff;
        end else begin
            mode_reg   <= mode_next;
            opaque_reg <= opaque_next;
            clear_reg  <= clear_next;
            alpha_reg  <= alpha_next;
        end
    end

    // pipeline valid and load control
    sopb_pipe_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .out_ready (m_ready),
        .in_ready  (s_ready),
        .ctrl      (ctrl)
    );

    // stage 1: input register
    logic [31:0] s1_src_reg, s1_dst_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.load[0]) begin
            s1_src_reg <= s_src_pixel;
            s1_dst_reg <= s_dst_pixel;
        end
    end

    // stage 2: channel products
    logic [3:0][15:0] s2_psa_reg, s2_psa_next;
    logic [3:0][15:0] s2_pd_reg,  s2_pd_next;
    logic [12:0] s2_p2r_reg, s2_p2r_next;
    logic [13:0] s2_p2g_reg, s2_p2g_next;
    logic [12:0] s2_p2b_reg, s2_p2b_next;
    logic [10:0] s2_sr_reg, s2_sr_next, s2_dr_reg, s2_dr_next;
    logic [14:0] s2_sg_reg, s2_sg_next, s2_dg_reg, s2_dg_next;
    logic [10:0] s2_sb_reg, s2_sb_next, s2_db_reg, s2_db_next;
    logic [31:0] s2_src_reg, s2_dst_reg;
    logic [7:0]  s1_dst_k, s1_sia, s1_inv_a;
    logic [8:0]  s1_b_s, s1_b_d;

    always_comb begin
        s1_sia   = ~s1_src_reg[31:24];
        s1_inv_a = ~alpha_reg;
        s1_dst_k = (mode_reg == MODE_RGB_ON_RGB) ? s1_inv_a : s1_sia;
        s1_b_s   = {1'b0, alpha_reg} + 9'd1;
        s1_b_d   = {1'b0, s1_inv_a} + 9'd1;
        for (int i = 0; i < 4; i++) begin
            s2_psa_next[i] = 16'(s1_src_reg[8*i +: 8]) * 16'(alpha_reg);
            s2_pd_next[i]  = 16'(s1_dst_reg[8*i +: 8]) * 16'(s1_dst_k);
        end
        // opaque argb on 565 field products
        s2_p2r_next = 13'(s1_dst_reg[15:11]) * 13'(s1_sia);
        s2_p2g_next = 14'(s1_dst_reg[10:5])  * 14'(s1_sia);
        s2_p2b_next = 13'(s1_dst_reg[4:0])   * 13'(s1_sia);
        // 565 on 565 field products
        s2_sr_next = 11'(s1_src_reg[15:11]) * 11'(s1_b_s[8:2]);
        s2_sg_next = 15'(s1_src_reg[10:5])  * 15'(s1_b_s);
        s2_sb_next = 11'(s1_src_reg[4:0])   * 11'(s1_b_s[8:2]);
        s2_dr_next = 11'(s1_dst_reg[15:11]) * 11'(s1_b_d[8:2]);
        s2_dg_next = 15'(s1_dst_reg[10:5])  * 15'(s1_b_d);
        s2_db_next = 11'(s1_dst_reg[4:0])   * 11'(s1_b_d[8:2]);
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load[1]) begin
            s2_psa_reg <= s2_psa_next;
            s2_pd_reg  <= s2_pd_next;
            s2_p2r_reg <= s2_p2r_next;
            s2_p2g_reg <= s2_p2g_next;
            s2_p2b_reg <= s2_p2b_next;
            s2_sr_reg  <= s2_sr_next;
            s2_sg_reg  <= s2_sg_next;
            s2_sb_reg  <= s2_sb_next;
            s2_dr_reg  <= s2_dr_next;
            s2_dg_reg  <= s2_dg_next;
            s2_db_reg  <= s2_db_next;
            s2_src_reg <= s1_src_reg;
            s2_dst_reg <= s1_dst_reg;
        end
    end

    // stage 3: rounding and the single-multiply results
    logic [31:0] s3_sp_reg, s3_sp_next;
    logic [31:0] s3_dm_reg, s3_dm_next;
    logic [31:0] s3_it_reg, s3_it_next;
    logic [15:0] s3_m2o_reg, s3_m2o_next;
    logic [15:0] s3_m4_reg, s3_m4_next;
    logic [31:0] s3_src_reg, s3_dst_reg;
    logic [24:0] ur;
    logic [19:0] ug;
    logic [13:0] ub;
    logic [16:0] rr;
    logic [15:0] rg, rbv;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            s3_sp_next[8*i +: 8] = round_byte(17'(s2_psa_reg[i]));
            s3_dm_next[8*i +: 8] = round_byte(17'(s2_pd_reg[i]));
            s3_it_next[8*i +: 8] = round_byte(17'(s2_pd_reg[i]) + 17'(s2_psa_reg[i]));
        end
        // opaque argb on 565, per-channel rounding
        ur  = {1'b0, s2_p2r_reg, 11'd0} + {9'd0, s2_p2r_reg, 3'd0} + 25'h8000;
        ug  = {1'b0, s2_p2g_reg, 5'd0} + {9'd0, s2_p2g_reg[13:3]} + 20'h400;
        ub  = {1'b0, s2_p2b_reg} + {9'd0, s2_p2b_reg[12:8]} + 14'h10;
        rr  = {1'b0, s2_src_reg[23:19], 11'd0} + {1'b0, ur[23:8]};
        rg  = {5'd0, s2_src_reg[15:10], 5'd0} + {4'd0, ug[19:8]};
        rbv = {11'd0, s2_src_reg[7:3]} + {10'd0, ub[13:8]};
        if (s2_src_reg[31:24] == 8'hff) begin
            s3_m2o_next = to_565(s2_src_reg);
        end else if (s2_src_reg[31:24] == 8'h00) begin
            s3_m2o_next = s2_dst_reg[15:0];
        end else begin
            s3_m2o_next = {rr[15:11], 11'd0} | {5'd0, rg[10:5], 5'd0} | rbv;
        end
        s3_m4_next = pick_565(s2_sr_reg, s2_sg_reg, s2_sb_reg)
                   + pick_565(s2_dr_reg, s2_dg_reg, s2_db_reg);
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load[2]) begin
            s3_sp_reg  <= s3_sp_next;
            s3_dm_reg  <= s3_dm_next;
            s3_it_reg  <= s3_it_next;
            s3_m2o_reg <= s3_m2o_next;
            s3_m4_reg  <= s3_m4_next;
            s3_src_reg <= s2_src_reg;
            s3_dst_reg <= s2_dst_reg;
        end
    end

    // stage 4: destination times inverse scaled source alpha, early results
    logic [3:0][15:0] s4_pd_reg, s4_pd_next;
    logic [10:0] s4_dr_reg, s4_dr_next;
    logic [14:0] s4_dg_reg, s4_dg_next;
    logic [10:0] s4_db_reg, s4_db_next;
    logic [31:0] s4_sp_reg;
    logic [31:0] s4_early_reg, s4_early_next;
    logic [7:0]  s3_k;
    logic [8:0]  s3_b;

    always_comb begin
        s3_k = ~s3_sp_reg[31:24];
        s3_b = {1'b0, s3_k} + 9'd1;
        for (int i = 0; i < 4; i++) begin
            s4_pd_next[i] = 16'(s3_dst_reg[8*i +: 8]) * 16'(s3_k);
        end
        s4_dr_next = 11'(s3_dst_reg[15:11]) * 11'(s3_b[8:2]);
        s4_dg_next = 15'(s3_dst_reg[10:5])  * 15'(s3_b);
        s4_db_next = 11'(s3_dst_reg[4:0])   * 11'(s3_b[8:2]);

        // results that need no second multiply
        s4_early_next = s3_dst_reg;
        unique case (mode_reg)
            MODE_ARGB_ON_ARGB: begin
                if (opaque_reg) begin
                    if (s3_src_reg[31:24] == 8'hff) begin
                        s4_early_next = s3_src_reg;
                    end else if (s3_src_reg != 32'd0) begin
                        s4_early_next = s3_src_reg + s3_dm_reg;
                    end
                end
            end
            MODE_RGB_ON_RGB: begin
                if (opaque_reg) begin
                    s4_early_next = s3_src_reg;
                end else if (!clear_reg) begin
                    s4_early_next = s3_it_reg;
                end
            end
            MODE_ARGB_ON_RGB565: begin
                s4_early_next = {16'd0, s3_m2o_reg};
            end
            MODE_RGB_ON_RGB565: begin
                s4_early_next = {16'd0, to_565(s3_src_reg)};
            end
            MODE_RGB565_ON_565: begin
                if (opaque_reg) begin
                    s4_early_next = {16'd0, s3_src_reg[15:0]};
                end else if (clear_reg) begin
                    s4_early_next = {16'd0, s3_dst_reg[15:0]};
                end else begin
                    s4_early_next = {16'd0, s3_m4_reg};
                end
            end
            default: begin
                s4_early_next = s3_dst_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load[3]) begin
            s4_pd_reg    <= s4_pd_next;
            s4_dr_reg    <= s4_dr_next;
            s4_dg_reg    <= s4_dg_next;
            s4_db_reg    <= s4_db_next;
            s4_sp_reg    <= s3_sp_reg;
            s4_early_reg <= s4_early_next;
        end
    end

    // stage 5: constant-alpha results and output register
    logic [31:0] s5_result_reg, s5_result_next;
    logic [31:0] dm2;
    logic [15:0] late_565;
    logic        late_32, late_16;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            dm2[8*i +: 8] = round_byte(17'(s4_pd_reg[i]));
        end
        late_565 = to_565(s4_sp_reg) + pick_565(s4_dr_reg, s4_dg_reg, s4_db_reg);
        late_32  = (mode_reg == MODE_ARGB_ON_ARGB) && !opaque_reg && !clear_reg;
        late_16  = ((mode_reg == MODE_ARGB_ON_RGB565) || (mode_reg == MODE_RGB_ON_RGB565))
                   && !opaque_reg;
        priority if (late_32) begin
            s5_result_next = s4_sp_reg + dm2;
        end else if (late_16) begin
            s5_result_next = {16'd0, late_565};
        end else begin
            s5_result_next = s4_early_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load[4]) begin
            s5_result_reg <= s5_result_next;
        end
    end

    assign m_valid        = ctrl.valid[NUM_STAGES-1];
    assign m_result_pixel = s5_result_reg;

    // an accepted item that does not leave adds one to the occupancy
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !(m_valid && m_ready))
        |=> ($countones(ctrl.valid) == $past($countones(ctrl.valid)) + 1))
        else $error("pipeline occupancy did not grow on accept");

    // a free output side lets every stage move
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while output is ready");

    // 565 destinations leave the upper half clear
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && ((mode_reg == MODE_ARGB_ON_RGB565) || (mode_reg == MODE_RGB_ON_RGB565)
                     || (mode_reg == MODE_RGB565_ON_565)))
        |-> (m_result_pixel[31:16] == 16'd0))
        else $error("565 result has upper bits set");

endmodule

`default_nettype wire

// ===== rtl/sopb_pipe_ctrl.sv =====
`default_nettype none

module sopb_pipe_ctrl (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 in_valid,
    input  wire                 out_ready,
    output logic                in_ready,
    output sopb_pkg::pipe_ctrl_t ctrl
);
    import sopb_pkg::*;

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] load;

    // a stage loads when it is empty or its content moves on
    always_comb begin
        load[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || out_ready;
        for (int i = NUM_STAGES - 2; i >= 0; i--) begin
            load[i] = !valid_reg[i] || load[i+1];
        end
    end

    // valid bits follow the data
    always_comb begin
        valid_next[0] = load[0] ? in_valid : valid_reg[0];
        for (int i = 1; i < NUM_STAGES; i++) begin
            valid_next[i] = load[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready = load[0];
    assign ctrl     = '{load: load, valid: valid_reg};

endmodule

`default_nettype wire

// ===== sim/tb_source_over_pixel_blender_unit.sv =====
`default_nettype none

module tb_source_over_pixel_blender_unit;
    import sopb_pkg::*;

    // codes that the block treats as no operation
    localparam logic [2:0] MODE_SPARE_LO = 3'd5;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;

    // pixel format constants
    localparam logic [31:0] ARGB_OPAQUE = 32'hff000000;
    localparam logic [31:0] F565_R      = 32'h0000f800;
    localparam logic [31:0] F565_G      = 32'h000007e0;
    localparam logic [31:0] F565_B      = 32'h0000001f;
    localparam logic [31:0] F565_RB     = 32'h0000f81f;
    localparam logic [31:0] HALF_R      = 32'h80 << 8;
    localparam logic [31:0] HALF_G      = 32'h80 << 3;
    localparam logic [31:0] HALF_B      = 32'h80 >> 3;

    localparam int RAND_PHASES    = 16;
    localparam int ITEMS_PER_PHASE = 125;

    typedef struct packed {
        logic [31:0] src;
        logic [31:0] dst;
    } pixel_pair_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    wire         s_ready;
    logic [31:0] s_src_pixel = '0;
    logic [31:0] s_dst_pixel = '0;
    wire         m_valid;
    logic        m_ready = 1'b0;
    wire  [31:0] m_result_pixel;
    logic        cfg_we = 1'b0;
    logic        cfg_idx = REG_BLEND_MODE;
    logic [8:0]  cfg_wdata = '0;

    // register copies used for prediction
    logic [2:0]  cur_mode = MODE_ARGB_ON_ARGB;
    logic [8:0]  cur_alpha = 9'd256;

    pixel_pair_t pair_q[$];
    logic [31:0] blended_q[$];

    logic        src_idle = 1'b0;
    logic        snk_idle = 1'b0;
    int          src_gap = 0;
    int          snk_gap = 0;
    int          sent_cnt = 0;
    int          result_cnt = 0;
    int          fail_cnt = 0;
    int          cfg_cnt = 0;
    logic [7:0]  modes_seen = '0;

    source_over_pixel_blender_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_src_pixel   (s_src_pixel),
        .s_dst_pixel   (s_dst_pixel),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_pixel(m_result_pixel),
        .cfg_we        (cfg_we),
        .cfg_idx       (cfg_idx),
        .cfg_wdata     (cfg_wdata)
    );

    always #10 aclk = ~aclk;

    // ---------------- pixel math ----------------

    // rounded byte product: (t + (t >> 8) + 128) >> 8
    function automatic logic [31:0] round_prod(input logic [31:0] t);
        logic [31:0] u;
        u = (t + (t >> 8) + 32'd128) >> 8;
        return {24'd0, u[7:0]};
    endfunction

    function automatic logic [31:0] scale_bytes(input logic [31:0] px, input logic [7:0] a);
        logic [31:0] r;
        int sh;
        r = '0;
        for (sh = 0; sh < 32; sh += 8)
            r |= round_prod({24'd0, px[sh+:8]} * {24'd0, a}) << sh;
        return r;
    endfunction

    // per-byte interpolation x*a + y*b
    function automatic logic [31:0] mix_bytes(input logic [31:0] x, input logic [7:0] a,
                                              input logic [31:0] y, input logic [7:0] b);
        logic [31:0] r;
        logic [31:0] t;
        int sh;
        r = '0;
        for (sh = 0; sh < 32; sh += 8) begin
            t = {24'd0, x[sh+:8]} * {24'd0, a} + {24'd0, y[sh+:8]} * {24'd0, b};
            r |= round_prod(t) << sh;
        end
        return r;
    endfunction

    function automatic logic [31:0] scale_565(input logic [31:0] x, input logic [7:0] a);
        logic [31:0] b;
        logic [31:0] t;
        b = {24'd0, a} + 32'd1;
        t = (((x & F565_G) * b) >> 8) & F565_G;
        t |= (((x & F565_RB) * (b >> 2)) >> 6) & F565_RB;
        return t & 32'h0000ffff;
    endfunction

    // truncating 888 to 565
    function automatic logic [31:0] pack_565(input logic [31:0] c);
        return ((c >> 3) & F565_B) | ((c >> 5) & F565_G) | ((c >> 8) & F565_R);
    endfunction

    // argb source on 565 with a layer alpha below opaque
    function automatic logic [31:0] argb565_layer(input logic [31:0] s, input logic [31:0] d,
                                                  input logic [7:0] a);
        logic [31:0] sp;
        sp = scale_bytes(s, a);
        return (pack_565(sp) + scale_565(d, 8'hff - sp[31:24])) & 32'h0000ffff;
    endfunction

    // argb source on 565, opaque layer, per-channel form
    function automatic logic [31:0] argb565_opaque(input logic [31:0] s, input logic [31:0] d);
        logic [31:0] sia, sr, sg, sb, xr, xg, xb, rr, rg, rb;
        if (s[31:24] == 8'hff)
            return pack_565(s);
        if (s[31:24] == 8'h00)
            return d;
        sia = 32'd255 - {24'd0, s[31:24]};
        sr = (s >> 8) & F565_R;
        sg = (s >> 5) & F565_G;
        sb = (s >> 3) & F565_B;
        xr = (d & F565_R) * sia;
        xg = (d & F565_G) * sia;
        xb = (d & F565_B) * sia;
        rr = sr + ((xr + (xr >> 8) + HALF_R) >> 8);
        rg = sg + ((xg + (xg >> 8) + HALF_G) >> 8);
        rb = sb + ((xb + (xb >> 8) + HALF_B) >> 8);
        return ((rr & F565_R) | (rg & F565_G) | rb) & 32'h0000ffff;
    endfunction

    // composited destination pixel for one source/destination pair
    function automatic logic [31:0] predict_pixel(input logic [2:0] mode, input logic [8:0] alpha,
                                                  input logic [31:0] s, input logic [31:0] d);
        int unsigned ca;
        logic [7:0]  a;
        logic [31:0] d16;
        logic [31:0] sp;
        logic [31:0] r;
        ca  = (alpha > 9'd256) ? 256 : alpha;
        a   = 8'((ca * 255) >> 8);
        d16 = d & 32'h0000ffff;
        case (mode)
            MODE_ARGB_ON_ARGB: begin
                if (ca == 256) begin
                    if (s >= ARGB_OPAQUE)
                        r = s;
                    else if (s != 0)
                        r = s + scale_bytes(d, 8'hff - s[31:24]);
                    else
                        r = d;
                end else if (ca != 0) begin
                    sp = scale_bytes(s, a);
                    r  = sp + scale_bytes(d, 8'hff - sp[31:24]);
                end else begin
                    r = d;
                end
            end
            MODE_RGB_ON_RGB: begin
                if (ca == 256)
                    r = s;
                else if (ca != 0)
                    r = mix_bytes(d, 8'hff - a, s, a);
                else
                    r = d;
            end
            MODE_ARGB_ON_RGB565: begin
                r = (ca == 256) ? argb565_opaque(s, d16) : argb565_layer(s, d16, a);
            end
            MODE_RGB_ON_RGB565: begin
                r = (ca == 256) ? pack_565(s) : argb565_layer(s, d16, a);
            end
            MODE_RGB565_ON_565: begin
                if (ca == 256)
                    r = s & 32'h0000ffff;
                else if (ca != 0)
                    r = (scale_565(s & 32'h0000ffff, a) + scale_565(d16, 8'hff - a))
                        & 32'h0000ffff;
                else
                    r = d16;
            end
            default: r = d;
        endcase
        return r;
    endfunction

    // ---------------- stimulus helpers ----------------

    // idle length: mostly short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] rand_src();
        logic [7:0] al;
        case ($urandom_range(0, 9))
            0: return 32'h00000000;
            1: return 32'hffffffff;
            2: return {8'hff, 24'($urandom)};
            3: return {8'h00, 24'($urandom)};
            4, 5, 6: begin
                // validly premultiplied: no channel above alpha
                al = 8'($urandom);
                return {al, 8'($urandom_range(0, al)), 8'($urandom_range(0, al)),
                        8'($urandom_range(0, al))};
            end
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_dst();
        case ($urandom_range(0, 9))
            0: return 32'h00000000;
            1: return 32'hffffffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [8:0] rand_alpha();
        case ($urandom_range(0, 9))
            0: return 9'd0;
            1: return 9'd1;
            2: return 9'd255;
            3: return 9'd256;
            4: return 9'd257;
            5: return 9'd511;
            6: return 9'($urandom_range(257, 511));
            default: return 9'($urandom_range(0, 256));
        endcase
    endfunction

    task automatic add_pair(input logic [31:0] src, input logic [31:0] dst);
        pixel_pair_t p;
        p.src = src;
        p.dst = dst;
        pair_q.push_back(p);
    endtask

    // wait until every queued item has come back, then let the pipe empty
    task automatic drain_all();
        do @(negedge aclk);
        while (pair_q.size() != 0 || s_valid || blended_q.size() != 0);
        repeat (NUM_STAGES + 2) @(negedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [8:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        if (idx == REG_BLEND_MODE)
            cur_mode = val[2:0];
        else
            cur_alpha = val;
        cfg_cnt++;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(input logic [2:0] mode, input logic [8:0] alpha);
        drain_all();
        write_reg(REG_BLEND_MODE, {6'd0, mode});
        write_reg(REG_LAYER_ALPHA, alpha);
        modes_seen[mode] = 1'b1;
    endtask

    // ---------------- driver ----------------

    always @(posedge aclk) begin : pixel_driver
        logic        nxt_valid;
        pixel_pair_t p;
        if (!aresetn) begin
            s_valid     <= 1'b0;
            s_src_pixel <= '0;
            s_dst_pixel <= '0;
            src_gap     <= 0;
        end else begin
            nxt_valid = s_valid;
            if (s_valid && s_ready) begin
                blended_q.push_back(predict_pixel(cur_mode, cur_alpha, s_src_pixel, s_dst_pixel));
                sent_cnt++;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (src_gap != 0) begin
                    src_gap <= src_gap - 1;
                end else if (pair_q.size() != 0) begin
                    p = pair_q.pop_front();
                    s_src_pixel <= p.src;
                    s_dst_pixel <= p.dst;
                    nxt_valid = 1'b1;
                    src_gap <= src_idle ? pick_gap() : 0;
                end
            end
            s_valid <= nxt_valid;
        end
    end

    // ---------------- monitor ----------------

    always @(posedge aclk) begin : result_monitor
        logic [31:0] exp_px;
        if (!aresetn) begin
            m_ready <= 1'b0;
            snk_gap <= 0;
        end else begin
            if (m_valid && m_ready) begin
                result_cnt++;
                if (blended_q.size() == 0) begin
                    $error("unexpected item: result_pixel actual %08h", m_result_pixel);
                    fail_cnt++;
                end else begin
                    exp_px = blended_q.pop_front();
                    if (m_result_pixel !== exp_px) begin
                        $error("result_pixel: expected %08h, actual %08h",
                               exp_px, m_result_pixel);
                        fail_cnt++;
                    end
                end
            end
            // random back-pressure
            if (snk_gap != 0) begin
                m_ready <= 1'b0;
                snk_gap <= snk_gap - 1;
            end else begin
                m_ready <= 1'b1;
                if (snk_idle && $urandom_range(0, 3) == 0)
                    snk_gap <= pick_gap();
            end
        end
    end

    // ---------------- test sequence ----------------

    initial begin : sequencer
        int ph;
        int n;
        logic [2:0] mode;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes and corner cases of each mode
        src_idle = 1'b1;
        snk_idle = 1'b1;
        // reset values: argb on argb, opaque layer
        add_pair(32'hffffffff, 32'h12345678);
        add_pair(32'h00000000, 32'hdeadbeef);
        add_pair(32'h80402010, 32'h11223344);
        add_pair(32'h10ffffff, 32'hffffffff);   // not premultiplied: carry between channels
        add_pair(32'hff000000, 32'haabbccdd);
        modes_seen[MODE_ARGB_ON_ARGB] = 1'b1;
        set_config(MODE_ARGB_ON_ARGB, 9'd128);
        add_pair(32'h80402010, 32'hffffffff);
        set_config(MODE_ARGB_ON_ARGB, 9'd0);
        add_pair(32'hffffffff, 32'h00000000);
        set_config(MODE_RGB_ON_RGB, 9'd256);
        add_pair(32'hffffffff, 32'h00000000);
        set_config(MODE_RGB_ON_RGB, 9'd1);
        add_pair(32'h00ffffff, 32'hff000000);
        add_pair(32'hffffffff, 32'h00000000);
        set_config(MODE_ARGB_ON_RGB565, 9'd256);
        add_pair(32'hffffffff, 32'hffff0000);   // upper destination bits ignored
        add_pair(32'h00ffffff, 32'h1234abcd);
        add_pair(32'h80ff80ff, 32'hffffffff);   // partial alpha, blue sum unmasked
        set_config(MODE_ARGB_ON_RGB565, 9'd255);
        add_pair(32'hffffffff, 32'hffffffff);
        set_config(MODE_RGB_ON_RGB565, 9'd256);
        add_pair(32'h00ffffff, 32'h00000000);
        set_config(MODE_RGB_ON_RGB565, 9'd64);  // source alpha used as in argb on 565
        add_pair(32'h7f123456, 32'hffff8421);
        set_config(MODE_RGB565_ON_565, 9'd256);
        add_pair(32'hffffffff, 32'hffffffff);
        set_config(MODE_RGB565_ON_565, 9'd300); // opacity above 256 acts as opaque
        add_pair(32'h0000f81f, 32'h00000000);
        set_config(MODE_RGB565_ON_565, 9'd0);
        add_pair(32'hffff1234, 32'hffffabcd);
        set_config(MODE_RGB565_ON_565, 9'd511);
        add_pair(32'h1234ffff, 32'h00000000);
        set_config(MODE_RGB565_ON_565, 9'd200);
        add_pair(32'hffff07e0, 32'h0000f81f);
        set_config(MODE_SPARE_LO, 9'd100);      // unused mode passes destination
        add_pair(32'h12345678, 32'h9abcdef0);
        set_config(MODE_SPARE_HI, 9'd256);
        add_pair(32'hfedcba98, 32'h76543210);

        // random phases, each under its own register setting
        for (ph = 0; ph < RAND_PHASES; ph++) begin
            n = $urandom_range(0, 19);
            mode = (n < 18) ? 3'(n % 5) : 3'($urandom_range(5, 7));
            set_config(mode, rand_alpha());
            src_idle = ($urandom_range(0, 3) != 0);
            snk_idle = ($urandom_range(0, 3) != 0);
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                add_pair(rand_src(), rand_dst());
                // sender holds off mid-phase until the pipe has emptied
                if (ph % 4 == 1 && n == ITEMS_PER_PHASE / 2)
                    drain_all();
            end
        end

        drain_all();
        $display("sent %0d items, got %0d results, %0d register writes, modes seen %08b",
                 sent_cnt, result_cnt, cfg_cnt, modes_seen);
        if (fail_cnt == 0 && blended_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // watchdog
    initial begin : watchdog
        #(60_000_000);
        $error("timeout: %0d results still outstanding", blended_q.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
